[sv/afs_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the frame selector.
`timescale 1ns / 1ps

package afs_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MAX_FRAMES_DEF    = 64;
  localparam int LOOK_BITS_DEF     = 16;
  localparam int DURATION_BITS_DEF = 16;

  // Fixed port widths.
  localparam int OP_W        = 2;
  localparam int DUR_IN_W    = 16;
  localparam int LOOK_IN_W   = 16;
  localparam int TIME_IN_W   = 32;
  localparam int STATUS_W    = 2;
  localparam int INDEX_OUT_W = 6;
  localparam int LOOK_OUT_W  = 16;
  localparam int HELD_OUT_W  = 7;
  localparam int TOTAL_OUT_W = 22;

  // A clipped elapsed time is never negative, so one bit less is enough.
  localparam int TIME_W    = TIME_IN_W - 1;
  localparam int DIV_CNT_W = $clog2(TIME_W);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_DUR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic respond;
    logic div_step;
    logic srch_issue;
    logic srch_cmp;
    logic look_issue;
    logic finish;
  } afs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic loop_en;
    logic div_last;
    logic srch_done;
  } afs_stat_t;

endpackage

[sv/afs_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module afs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/afs_ctrl.sv]
// Controller state machine that sequences the modulo and the binary search.
`timescale 1ns / 1ps

module afs_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [afs_pkg::OP_W-1:0]      op,
  input  afs_pkg::afs_stat_t            stat,
  output afs_pkg::afs_cmd_t             cmd,
  output logic                          busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SADDR = 3'd2;
  localparam logic [2:0] S_SCMP  = 3'd3;
  localparam logic [2:0] S_LADDR = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and commands.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (op == afs_pkg::OP_QUERY && !stat.empty) begin
            state_nxt = stat.loop_en ? S_DIV : S_SADDR;
          end else begin
            cmd.respond = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_SADDR;
        end
      end
      S_SADDR: begin
        if (stat.srch_done) begin
          state_nxt = S_LADDR;
        end else begin
          cmd.srch_issue = 1'b1;
          state_nxt      = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd.srch_cmp = 1'b1;
        state_nxt    = S_SADDR;
      end
      S_LADDR: begin
        cmd.look_issue = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        cmd.finish  = 1'b1;
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[sv/afs_datapath.sv]
// Datapath: frame tables, running totals, serial modulo and binary search registers.
`timescale 1ns / 1ps

module afs_datapath #(
  parameter int MAX_FRAMES    = afs_pkg::MAX_FRAMES_DEF,
  parameter int LOOK_BITS     = afs_pkg::LOOK_BITS_DEF,
  parameter int DURATION_BITS = afs_pkg::DURATION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  afs_pkg::afs_cmd_t                   cmd,
  output afs_pkg::afs_stat_t                  stat,
  input  logic [afs_pkg::OP_W-1:0]            in_operation,
  input  logic [afs_pkg::DUR_IN_W-1:0]        in_frame_duration,
  input  logic [afs_pkg::LOOK_IN_W-1:0]       in_frame_look,
  input  logic signed [afs_pkg::TIME_IN_W-1:0] in_elapsed_time,
  input  logic                                cfg_we,
  input  logic                                cfg_loop_enable,
  output logic                                out_valid,
  output logic [afs_pkg::STATUS_W-1:0]        out_status,
  output logic [afs_pkg::INDEX_OUT_W-1:0]     out_selected_index,
  output logic [afs_pkg::LOOK_OUT_W-1:0]      out_selected_look,
  output logic [afs_pkg::HELD_OUT_W-1:0]      out_frames_held,
  output logic [afs_pkg::TOTAL_OUT_W-1:0]     out_total_ticks
);

  localparam int DUR_W = (DURATION_BITS < afs_pkg::DUR_IN_W) ? DURATION_BITS
                                                              : afs_pkg::DUR_IN_W;
  localparam int LK_W  = (LOOK_BITS < afs_pkg::LOOK_IN_W) ? LOOK_BITS : afs_pkg::LOOK_IN_W;
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W = DUR_W + $clog2(MAX_FRAMES);
  localparam int TW    = afs_pkg::TIME_W;
  localparam int DCW   = afs_pkg::DIV_CNT_W;
  localparam int IOW   = afs_pkg::INDEX_OUT_W;
  localparam int LOW   = afs_pkg::LOOK_OUT_W;
  localparam int HOW   = afs_pkg::HELD_OUT_W;
  localparam int TOW   = afs_pkg::TOTAL_OUT_W;

  // Control state.
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] sum_r;
  logic             loop_r;
  logic             out_valid_r;

  // Work registers.
  logic [TW-1:0]    t_r;
  logic [SUM_W-1:0] rem_r;
  logic [DCW-1:0]   div_cnt_r;
  logic [CNT_W-1:0] lo_r;
  logic [CNT_W-1:0] hi_r;
  logic [CNT_W-1:0] mid_r;
  logic [IDX_W-1:0] idx_r;

  // Result registers.
  logic [afs_pkg::STATUS_W-1:0] res_status_r;
  logic [IOW-1:0]               res_index_r;
  logic [LOW-1:0]               res_look_r;

  logic [DUR_W-1:0]             dur;
  logic [LK_W-1:0]              look_in;
  logic                         dur_zero;
  logic                         full;
  logic [SUM_W-1:0]             sum_add;
  logic                         append_ok;
  logic [afs_pkg::STATUS_W-1:0] imm_status;
  logic [TW-1:0]                t_load;
  logic [SUM_W:0]               trial;
  logic [SUM_W:0]               diff;
  logic                         ge;
  logic [SUM_W-1:0]             rem_nxt;
  logic [CNT_W:0]               mid_sum;
  logic [CNT_W-1:0]             mid;
  logic [CNT_W-1:0]             pick;
  logic [SUM_W-1:0]             rd_end;
  logic [LK_W-1:0]              rd_look;
  logic                         le;

  // Append decode.
  assign dur       = in_frame_duration[DUR_W-1:0];
  assign look_in   = in_frame_look[LK_W-1:0];
  assign dur_zero  = (dur == '0);
  assign full      = (cnt_r >= CNT_W'(MAX_FRAMES));
  assign sum_add   = sum_r + SUM_W'(dur);
  assign append_ok = cmd.accept && (in_operation == afs_pkg::OP_APPEND) && !dur_zero && !full;

  // Status of items that answer in the accept cycle.
  always_comb begin
    case (in_operation)
      afs_pkg::OP_CLEAR:  imm_status = afs_pkg::ST_OK;
      afs_pkg::OP_APPEND: imm_status = dur_zero ? afs_pkg::ST_ZERO_DUR :
                                       (full ? afs_pkg::ST_FULL : afs_pkg::ST_OK);
      afs_pkg::OP_QUERY:  imm_status = afs_pkg::ST_EMPTY;
      default:            imm_status = afs_pkg::ST_OK;
    endcase
  end

  // Negative elapsed times clip to zero.
  assign t_load = in_elapsed_time[afs_pkg::TIME_IN_W-1] ? '0 : in_elapsed_time[TW-1:0];

  // One restoring division step per cycle.
  assign trial   = {rem_r, t_r[TW-1]};
  assign diff    = trial - {1'b0, sum_r};
  assign ge      = (trial >= {1'b0, sum_r});
  assign rem_nxt = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];

  // Binary search probe and final clamp to the last frame.
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CNT_W:1];
  assign le      = (TW'(rd_end) <= t_r);
  assign pick    = (lo_r == cnt_r) ? (cnt_r - CNT_W'(1)) : lo_r;

  // End-time and look tables.
  afs_ram #(.WIDTH(SUM_W), .DEPTH(MAX_FRAMES)) u_end_ram (
    .clk   (clk),
    .we    (append_ok),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (sum_add),
    .raddr (mid[IDX_W-1:0]),
    .rdata (rd_end)
  );

  afs_ram #(.WIDTH(LK_W), .DEPTH(MAX_FRAMES)) u_look_ram (
    .clk   (clk),
    .we    (append_ok),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (look_in),
    .raddr (pick[IDX_W-1:0]),
    .rdata (rd_look)
  );

  // Table size, running total, loop register and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sum_r       <= '0;
      loop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
      if (cfg_we) begin
        loop_r <= cfg_loop_enable;
      end
      if (cmd.accept && in_operation == afs_pkg::OP_CLEAR) begin
        cnt_r <= '0;
        sum_r <= '0;
      end else if (append_ok) begin
        cnt_r <= cnt_r + CNT_W'(1);
        sum_r <= sum_add;
      end
    end
  end

  // Query work registers and result payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_r       <= t_load;
      rem_r     <= '0;
      div_cnt_r <= '0;
      lo_r      <= '0;
      hi_r      <= cnt_r;
      if (cmd.respond) begin
        res_status_r <= imm_status;
        res_index_r  <= '0;
        res_look_r   <= '0;
      end
    end
    if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + DCW'(1);
      t_r       <= stat.div_last ? TW'(rem_nxt) : {t_r[TW-2:0], 1'b0};
    end
    if (cmd.srch_issue) begin
      mid_r <= mid;
    end
    if (cmd.srch_cmp) begin
      if (le) begin
        lo_r <= mid_r + CNT_W'(1);
      end else begin
        hi_r <= mid_r;
      end
    end
    if (cmd.look_issue) begin
      idx_r <= pick[IDX_W-1:0];
    end
    if (cmd.finish) begin
      res_status_r <= afs_pkg::ST_OK;
      res_index_r  <= IOW'(idx_r);
      res_look_r   <= LOW'(rd_look);
    end
  end

  // Status back to the controller.
  assign stat.empty     = (cnt_r == '0);
  assign stat.loop_en   = loop_r;
  assign stat.div_last  = (div_cnt_r == DCW'(TW - 1));
  assign stat.srch_done = (lo_r == hi_r);

  // Result ports.
  assign out_valid          = out_valid_r;
  assign out_status         = res_status_r;
  assign out_selected_index = res_index_r;
  assign out_selected_look  = res_look_r;
  assign out_frames_held    = HOW'(cnt_r);
  assign out_total_ticks    = TOW'(sum_r);

endmodule

[sv/animation_frame_selector.sv]
// Top level: animation frame table with elapsed-time lookup.
// Clear, append, unknown operations and queries on an empty table give their result
// in the cycle after the beat is accepted, and busy stays low, so one may follow per cycle.
// A query runs a bit-serial modulo when looping is on, then S binary search probes (at most
// log2(MAX_FRAMES) + 1), each a read and a compare on the end-time RAM, then a look-table
// read and the finish step. The result strobe lasts one cycle; the receiver cannot stall.
// Synchronous active-low reset empties the table and clears the loop setting.
`timescale 1ns / 1ps

module animation_frame_selector #(
  parameter int MAX_FRAMES    = afs_pkg::MAX_FRAMES_DEF,
  parameter int LOOK_BITS     = afs_pkg::LOOK_BITS_DEF,
  parameter int DURATION_BITS = afs_pkg::DURATION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [afs_pkg::OP_W-1:0]             in_operation,
  input  logic [afs_pkg::DUR_IN_W-1:0]         in_frame_duration,
  input  logic [afs_pkg::LOOK_IN_W-1:0]        in_frame_look,
  input  logic signed [afs_pkg::TIME_IN_W-1:0] in_elapsed_time,
  output logic                                 out_valid,
  output logic [afs_pkg::STATUS_W-1:0]         out_status,
  output logic [afs_pkg::INDEX_OUT_W-1:0]      out_selected_index,
  output logic [afs_pkg::LOOK_OUT_W-1:0]       out_selected_look,
  output logic [afs_pkg::HELD_OUT_W-1:0]       out_frames_held,
  output logic [afs_pkg::TOTAL_OUT_W-1:0]      out_total_ticks,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_loop_enable
);

  afs_pkg::afs_cmd_t  cmd;
  afs_pkg::afs_stat_t stat;
  logic               cfg_we;

  // The loop register takes a beat in any cycle.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  afs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_operation),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  afs_datapath #(
    .MAX_FRAMES    (MAX_FRAMES),
    .LOOK_BITS     (LOOK_BITS),
    .DURATION_BITS (DURATION_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operation       (in_operation),
    .in_frame_duration  (in_frame_duration),
    .in_frame_look      (in_frame_look),
    .in_elapsed_time    (in_elapsed_time),
    .cfg_we             (cfg_we),
    .cfg_loop_enable    (cfg_loop_enable),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_selected_index (out_selected_index),
    .out_selected_look  (out_selected_look),
    .out_frames_held    (out_frames_held),
    .out_total_ticks    (out_total_ticks)
  );

  // A long query ends with a strobe in the cycle busy drops.
  a_fin_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("query finished without a result strobe");

  // Busy only rises after an accepted query on a non-empty table.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(cmd.accept && in_operation == afs_pkg::OP_QUERY && !stat.empty))
    else $error("busy raised without a query");

  // An empty-table status only comes with an empty table.
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == afs_pkg::ST_EMPTY |-> stat.empty)
    else $error("empty status reported while frames are held");

  // A clear leaves no frames and no total behind.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && in_operation == afs_pkg::OP_CLEAR |=> stat.empty && out_total_ticks == '0)
    else $error("clear did not empty the table");

endmodule
